### hw/rtl/sact_pkg.sv
// Shared types and constants for the cache tag controller.
package sact_pkg;

	localparam int WAYS_DEF       = 2;
	localparam int SETS_DEF       = 16;
	localparam int LINE_WORDS_DEF = 4;
	localparam int QDEPTH         = 2;

	localparam logic [31:0] UNC_START_RST = 32'hF000_0000;
	localparam logic [31:0] UNC_LAST_RST  = 32'hFFFF_FFFE;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FLUSH = 2'd2,
		OP_INVAL = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		POL_WB     = 2'd0,
		POL_WT_AL  = 2'd1,
		POL_WT_NAL = 2'd2,
		POL_UNDEF  = 2'd3
	} policy_t;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_POLICY = 2'd1,
		REG_USTART = 2'd2,
		REG_ULAST  = 2'd3
	} reg_idx_t;

	// Classified request handed from front to back
	typedef struct packed {
		op_t         op;
		logic        bypass;
		logic [31:0] address;
		logic        victim;
	} req_t;

	// Result transaction
	typedef struct packed {
		logic        hit;
		logic        way;
		logic        bypass;
		logic        wb_valid;
		logic [31:0] wb_addr;
		logic        fill_valid;
		logic [31:0] fill_addr;
		logic        wt;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic        last;
	} res_t;

endpackage

### hw/rtl/sact_front.sv
// Front end: configuration registers, request classification and request queue.
module sact_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        operation,
	input  logic [31:0]       address,
	input  logic              victim_way,
	output logic              q_valid,
	output sact_pkg::req_t    q_req,
	input  logic              q_pop,
	output logic              enable,
	output logic [1:0]        policy
);

	logic        enable_q;
	logic [1:0]  policy_q;
	logic [31:0] ustart_q;
	logic [31:0] ulast_q;

	logic [1:0]  reg_sel;
	assign reg_sel = paddr[3:2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			policy_q <= sact_pkg::POL_WB;
			ustart_q <= sact_pkg::UNC_START_RST;
			ulast_q  <= sact_pkg::UNC_LAST_RST;
		end else if (psel && penable && pwrite) begin
			unique case (sact_pkg::reg_idx_t'(reg_sel))
				sact_pkg::REG_ENABLE: enable_q <= pwdata[0];
				sact_pkg::REG_POLICY: policy_q <= pwdata[1:0];
				sact_pkg::REG_USTART: ustart_q <= pwdata;
				sact_pkg::REG_ULAST:  ulast_q  <= pwdata;
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (sact_pkg::reg_idx_t'(reg_sel))
			sact_pkg::REG_ENABLE: prdata = {31'd0, enable_q};
			sact_pkg::REG_POLICY: prdata = {30'd0, policy_q};
			sact_pkg::REG_USTART: prdata = ustart_q;
			sact_pkg::REG_ULAST:  prdata = ulast_q;
			default:              prdata = '0;
		endcase
	end

	assign enable = enable_q;
	assign policy = policy_q;

	// Classify incoming transaction
	sact_pkg::req_t new_req;
	always_comb begin
		new_req.op      = sact_pkg::op_t'(operation);
		new_req.address = address;
		new_req.victim  = victim_way;
		new_req.bypass  = !enable_q ||
			(address >= ustart_q && address <= ulast_q);
	end

	// Two-entry queue
	sact_pkg::req_t mem_q [sact_pkg::QDEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 2'(sact_pkg::QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= new_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

### hw/rtl/sact_back.sv
// Back end: tag store, hit/miss handling, flush walk and result register.
module sact_back #(
	parameter int WAYS       = sact_pkg::WAYS_DEF,
	parameter int SETS       = sact_pkg::SETS_DEF,
	parameter int LINE_WORDS = sact_pkg::LINE_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  sact_pkg::req_t q_req,
	output logic           q_pop,
	input  logic           enable,
	input  logic [1:0]     policy,
	output logic           out_valid,
	input  logic           out_stall,
	output sact_pkg::res_t res
);

	localparam int RB    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int RW    = $clog2(SETS);
	localparam int OB    = $clog2(LINE_WORDS) + 2;
	localparam int TW    = 32 - OB - RW;
	localparam int WB    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NL    = WAYS * SETS;
	localparam int LB    = (NL > 1) ? $clog2(NL) : 1;
	localparam int LC    = $clog2(NL + 1);

	logic          valid_q [NL];
	logic          dirty_q [NL];
	logic [TW-1:0] tag_q   [NL];
	logic [31:0]   hits_q, misses_q;

	logic        out_valid_q;
	sact_pkg::res_t res_q;
	logic [LC-1:0] fidx_q;

	logic slot_free;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	// Address decode
	logic [RB-1:0] row;
	logic [TW-1:0] tag;
	always_comb begin
		row = '0;
		if (SETS > 1) row = RB'(q_req.address >> OB);
		tag = TW'(q_req.address >> (OB + RW));
	end

	function automatic logic [31:0] base_of(input logic [TW-1:0] t, input logic [RB-1:0] r);
		logic [31:0] a;
		a = 32'(t) << (OB + RW);
		if (SETS > 1) a = a | (32'(r) << OB);
		return a;
	endfunction

	function automatic logic [LB-1:0] lidx(input logic [WB-1:0] w, input logic [RB-1:0] r);
		return LB'(32'(w) * SETS + 32'(r));
	endfunction

	// Way lookup across the addressed row
	logic          hit_any;
	logic [WB-1:0] hit_way;
	always_comb begin
		hit_any = 1'b0;
		hit_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valid_q[lidx(WB'(w), row)] && tag_q[lidx(WB'(w), row)] == tag) begin
				hit_any = 1'b1;
				hit_way = WB'(w);
			end
		end
	end

	// A single way always evicts way zero
	logic [WB-1:0] victim;
	assign victim = (WAYS > 1) ? WB'(q_req.victim) : '0;

	logic is_write, wb_pol;
	assign is_write = (q_req.op == sact_pkg::OP_WRITE);
	assign wb_pol   = (policy == sact_pkg::POL_WB);

	// Flush index splits into way (high bits) and row (low bits)
	logic [LB-1:0] fline;
	logic [LB-1:0] vline;
	logic [RB-1:0] frow;
	assign fline = LB'(fidx_q);
	assign vline = lidx(victim, row);
	always_comb begin
		frow = '0;
		if (SETS > 1) frow = RB'(fidx_q);
	end

	// Main sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			fidx_q      <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			for (int i = 0; i < NL; i++) begin
				valid_q[i] <= 1'b0;
				dirty_q[i] <= 1'b0;
				tag_q[i]   <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (slot_free && q_valid) begin
				res_q <= '0;
				res_q.hit_total  <= hits_q;
				res_q.miss_total <= misses_q;
				res_q.last       <= 1'b1;
				unique case (q_req.op)
					sact_pkg::OP_FLUSH: begin
						if (!enable || fidx_q == LC'(NL)) begin
							out_valid_q <= 1'b1;
							fidx_q      <= '0;
						end else begin
							fidx_q     <= fidx_q + 1'b1;
							valid_q[fline] <= 1'b0;
							dirty_q[fline] <= 1'b0;
							if (valid_q[fline] && dirty_q[fline] && wb_pol) begin
								out_valid_q     <= 1'b1;
								res_q.last      <= 1'b0;
								res_q.wb_valid  <= 1'b1;
								res_q.way       <= 1'(fidx_q >> RW);
								res_q.wb_addr   <= base_of(tag_q[fline], frow);
							end
						end
					end
					sact_pkg::OP_INVAL: begin
						out_valid_q <= 1'b1;
						hits_q <= '0;
						misses_q <= '0;
						res_q.hit_total  <= '0;
						res_q.miss_total <= '0;
						if (enable) begin
							for (int i = 0; i < NL; i++) begin
								valid_q[i] <= 1'b0;
								dirty_q[i] <= 1'b0;
							end
						end
					end
					default: begin
						out_valid_q <= 1'b1;
						if (q_req.bypass) begin
							res_q.bypass <= 1'b1;
						end else if (hit_any) begin
							hits_q <= hits_q + 1'b1;
							res_q.hit_total <= hits_q + 1'b1;
							res_q.hit <= 1'b1;
							res_q.way <= 1'(hit_way);
							res_q.wt  <= is_write && !wb_pol;
							if (is_write) dirty_q[lidx(hit_way, row)] <= 1'b1;
						end else begin
							misses_q <= misses_q + 1'b1;
							res_q.miss_total <= misses_q + 1'b1;
							if (is_write && policy == sact_pkg::POL_WT_NAL) begin
								res_q.wt <= 1'b1;
							end else begin
								res_q.way        <= 1'(victim);
								res_q.wt         <= is_write && !wb_pol;
								res_q.fill_valid <= 1'b1;
								res_q.fill_addr  <= base_of(tag, row);
								if (valid_q[vline] && dirty_q[vline] && wb_pol) begin
									res_q.wb_valid <= 1'b1;
									res_q.wb_addr  <= base_of(tag_q[vline], row);
								end
								valid_q[vline] <= 1'b1;
								tag_q[vline]   <= tag;
								dirty_q[vline] <= is_write;
							end
						end
					end
				endcase
			end
		end
	end

	// Retire request once its closing result is produced
	assign q_pop = slot_free && q_valid &&
		!(q_req.op == sact_pkg::OP_FLUSH && enable && fidx_q != LC'(NL));

endmodule

### hw/rtl/set_assoc_cache_tag_controller.sv
// Top level of the set-associative cache tag controller.
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall
//  out     | output    | out_valid / out_stall
//  cfg     | input     | APB psel/penable/pwrite, pready tied high
// The back end serves the queue head access into the result register.
// Flush walks all WAYS*SETS lines, one per cycle unless stalled, then closes.
// Reset clears all tags, valid and dirty bits and the counters at once.
// out_stall holds the result register; the queue keeps taking requests until full.
module set_assoc_cache_tag_controller #(
	parameter int WAYS       = sact_pkg::WAYS_DEF,
	parameter int SETS       = sact_pkg::SETS_DEF,
	parameter int LINE_WORDS = sact_pkg::LINE_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] address,
	input  logic        victim_way,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic        way,
	output logic        bypass,
	output logic        writeback_valid,
	output logic [31:0] writeback_address,
	output logic        fill_valid,
	output logic [31:0] fill_address,
	output logic        write_through,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic        last
);

	logic           q_valid, q_pop, enable;
	logic [1:0]     policy;
	sact_pkg::req_t q_req;
	sact_pkg::res_t res;

	assign pready = 1'b1;

	sact_front u_front (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.in_valid, .in_stall, .operation, .address, .victim_way,
		.q_valid, .q_req, .q_pop, .enable, .policy
	);

	sact_back #(.WAYS(WAYS), .SETS(SETS), .LINE_WORDS(LINE_WORDS)) u_back (
		.clk, .arst_n, .q_valid, .q_req, .q_pop, .enable, .policy,
		.out_valid, .out_stall, .res
	);

	assign hit               = res.hit;
	assign way               = res.way;
	assign bypass            = res.bypass;
	assign writeback_valid   = res.wb_valid;
	assign writeback_address = res.wb_addr;
	assign fill_valid        = res.fill_valid;
	assign fill_address      = res.fill_addr;
	assign write_through     = res.wt;
	assign hit_total         = res.hit_total;
	assign miss_total        = res.miss_total;
	assign last              = res.last;

endmodule

### dv/set_assoc_cache_tag_controller_test.sv
// Self-checking testbench for the set-associative cache tag controller.
`timescale 1ns / 100ps

module set_assoc_cache_tag_controller_test;

	localparam int NWAYS  = 2;
	localparam int NSETS  = 16;
	localparam int NLINES = NWAYS * NSETS;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [31:0] address;
	logic        victim_way;
	logic        out_valid;
	logic        out_stall;
	logic        hit;
	logic        way;
	logic        bypass;
	logic        writeback_valid;
	logic [31:0] writeback_address;
	logic        fill_valid;
	logic [31:0] fill_address;
	logic        write_through;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic        last;

	set_assoc_cache_tag_controller u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .address(address), .victim_way(victim_way),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .way(way), .bypass(bypass),
		.writeback_valid(writeback_valid), .writeback_address(writeback_address),
		.fill_valid(fill_valid), .fill_address(fill_address),
		.write_through(write_through), .hit_total(hit_total),
		.miss_total(miss_total), .last(last)
	);

	// Shadow state of the cache
	logic              sh_enable;
	sact_pkg::policy_t sh_policy;
	logic [31:0]       sh_ustart;
	logic [31:0]       sh_ulast;
	logic              sh_valid [NLINES];
	logic              sh_dirty [NLINES];
	logic [31:0]       sh_tag   [NLINES];
	logic [31:0]       sh_hits;
	logic [31:0]       sh_misses;

	sact_pkg::res_t pending_results [$];
	int   fail_count = 0;
	bit   idle_en = 1'b1;
	int   hold_req = 0;

	// Clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] line_base(logic [31:0] tag, int row);
		return (tag * NSETS + row) * 16;
	endfunction

	function automatic sact_pkg::res_t make_res(logic h, logic w, logic byp, logic wbv,
			logic [31:0] wba, logic fv, logic [31:0] fa, logic wt, logic lst);
		sact_pkg::res_t r;
		r.hit = h; r.way = w; r.bypass = byp; r.wb_valid = wbv; r.wb_addr = wba;
		r.fill_valid = fv; r.fill_addr = fa; r.wt = wt;
		r.hit_total = sh_hits; r.miss_total = sh_misses; r.last = lst;
		return r;
	endfunction

	// Compute the results of one request and queue them
	task automatic predict_access(sact_pkg::op_t op, logic [31:0] addr, logic vic);
		logic        wb_pol;
		logic        wt;
		logic [31:0] tag;
		int          row;
		int          idx;
		int          hw;
		wb_pol = (sh_policy == sact_pkg::POL_WB);
		if (op == sact_pkg::OP_FLUSH) begin
			if (sh_enable) begin
				for (int w = 0; w < NWAYS; w++)
					for (int s = 0; s < NSETS; s++) begin
						idx = w * NSETS + s;
						if (sh_valid[idx] && sh_dirty[idx] && wb_pol)
							pending_results.push_back(make_res(1'b0, w[0], 1'b0, 1'b1,
								line_base(sh_tag[idx], s), 1'b0, 32'h0, 1'b0, 1'b0));
						sh_valid[idx] = 1'b0;
						sh_dirty[idx] = 1'b0;
					end
			end
			pending_results.push_back(make_res(1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0,
				32'h0, 1'b0, 1'b1));
		end else if (op == sact_pkg::OP_INVAL) begin
			if (sh_enable)
				for (int i = 0; i < NLINES; i++) begin
					sh_valid[i] = 1'b0;
					sh_dirty[i] = 1'b0;
				end
			sh_hits = 0;
			sh_misses = 0;
			pending_results.push_back(make_res(1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0,
				32'h0, 1'b0, 1'b1));
		end else if (!sh_enable || (addr >= sh_ustart && addr <= sh_ulast)) begin
			pending_results.push_back(make_res(1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0,
				32'h0, 1'b0, 1'b1));
		end else begin
			row = addr[7:4];
			tag = addr >> 8;
			wt = (op == sact_pkg::OP_WRITE) && !wb_pol;
			hw = -1;
			for (int w = NWAYS - 1; w >= 0; w--)
				if (sh_valid[w * NSETS + row] && sh_tag[w * NSETS + row] == tag)
					hw = w;
			if (hw >= 0) begin
				sh_hits++;
				if (op == sact_pkg::OP_WRITE)
					sh_dirty[hw * NSETS + row] = 1'b1;
				pending_results.push_back(make_res(1'b1, hw[0], 1'b0, 1'b0, 32'h0, 1'b0,
					32'h0, wt, 1'b1));
			end else begin
				sh_misses++;
				if (op == sact_pkg::OP_WRITE && sh_policy == sact_pkg::POL_WT_NAL) begin
					pending_results.push_back(make_res(1'b0, 1'b0, 1'b0, 1'b0, 32'h0,
						1'b0, 32'h0, 1'b1, 1'b1));
				end else begin
					idx = vic * NSETS + row;
					if (sh_valid[idx] && sh_dirty[idx] && wb_pol)
						pending_results.push_back(make_res(1'b0, vic, 1'b0, 1'b1,
							line_base(sh_tag[idx], row), 1'b1, line_base(tag, row),
							wt, 1'b1));
					else
						pending_results.push_back(make_res(1'b0, vic, 1'b0, 1'b0, 32'h0,
							1'b1, line_base(tag, row), wt, 1'b1));
					sh_valid[idx] = 1'b1;
					sh_tag[idx] = tag;
					sh_dirty[idx] = (op == sact_pkg::OP_WRITE);
				end
			end
		end
	endtask

	// Send one request transaction, with an optional random gap after it
	task automatic send_req(sact_pkg::op_t op, logic [31:0] addr, logic vic);
		predict_access(op, addr, vic);
		in_valid <= 1'b1;
		operation <= op;
		address <= addr;
		victim_way <= vic;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Lower valid and wait for all results, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic reg_write(sact_pkg::reg_idx_t idx, logic [31:0] val);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			sact_pkg::REG_ENABLE: sh_enable = val[0];
			sact_pkg::REG_POLICY: sh_policy = sact_pkg::policy_t'(val[1:0]);
			sact_pkg::REG_USTART: sh_ustart = val;
			sact_pkg::REG_ULAST:  sh_ulast = val;
		endcase
	endtask

	// Address drawn mostly from a few tags so that hits and evictions happen
	function automatic logic [31:0] pick_addr();
		logic [31:0] a;
		a = $urandom;
		if ($urandom_range(0, 9) != 0)
			a[31:8] = 24'($urandom_range(0, 5) * 24'h01_0101);
		return a;
	endfunction

	function automatic sact_pkg::op_t pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return sact_pkg::OP_READ;
		if (r < 94) return sact_pkg::OP_WRITE;
		if (r < 97) return sact_pkg::OP_FLUSH;
		return sact_pkg::OP_INVAL;
	endfunction

	task automatic send_random(int n);
		for (int i = 0; i < n; i++)
			send_req(pick_op(), pick_addr(), 1'($urandom_range(0, 1)));
	endtask

	// Hits, misses, dirty evictions, flush, invalidate and address extremes
	task automatic test_directed();
		send_req(sact_pkg::OP_READ, 32'h0000_0000, 1'b0);
		send_req(sact_pkg::OP_WRITE, 32'h0000_0004, 1'b1);
		send_req(sact_pkg::OP_WRITE, 32'h0000_0100, 1'b1);
		send_req(sact_pkg::OP_READ, 32'h0000_0100, 1'b0);
		send_req(sact_pkg::OP_WRITE, 32'h0000_0200, 1'b1);
		send_req(sact_pkg::OP_READ, 32'hFFFF_FFFF, 1'b1);
		send_req(sact_pkg::OP_WRITE, 32'hEFFF_FFFC, 1'b0);
		send_req(sact_pkg::OP_READ, 32'hF000_0000, 1'b0);
		send_req(sact_pkg::OP_WRITE, 32'hFFFF_FFFE, 1'b1);
		send_req(sact_pkg::OP_FLUSH, 32'h0, 1'b0);
		send_req(sact_pkg::OP_READ, 32'h0000_0004, 1'b0);
		send_req(sact_pkg::OP_WRITE, 32'h1234_5670, 1'b0);
		send_req(sact_pkg::OP_INVAL, 32'hFFFF_FFFF, 1'b1);
		send_req(sact_pkg::OP_READ, 32'h1234_5670, 1'b0);
		// fill every line dirty and flush all of them
		for (int i = 0; i < NLINES; i++)
			send_req(sact_pkg::OP_WRITE, {24'(i + 7), i[3:0], 4'h0}, i[4]);
		send_req(sact_pkg::OP_FLUSH, 32'h0, 1'b1);
	endtask

	task automatic test_policies();
		reg_write(sact_pkg::REG_POLICY, 32'(sact_pkg::POL_WT_AL));
		send_random(30);
		reg_write(sact_pkg::REG_POLICY, 32'(sact_pkg::POL_WT_NAL));
		send_random(30);
		reg_write(sact_pkg::REG_POLICY, 32'(sact_pkg::POL_UNDEF));
		send_random(20);
		reg_write(sact_pkg::REG_POLICY, 32'(sact_pkg::POL_WB));
	endtask

	task automatic test_disabled();
		send_random(10);
		reg_write(sact_pkg::REG_ENABLE, 32'h0);
		send_random(20);
		send_req(sact_pkg::OP_FLUSH, 32'h0, 1'b0);
		send_req(sact_pkg::OP_INVAL, 32'h0, 1'b0);
		reg_write(sact_pkg::REG_ENABLE, 32'h1);
		send_random(10);
	endtask

	task automatic test_region();
		reg_write(sact_pkg::REG_USTART, 32'h0000_0000);
		reg_write(sact_pkg::REG_ULAST, 32'hFFFF_FFFF);
		send_random(10);
		reg_write(sact_pkg::REG_USTART, 32'h0001_0000);
		reg_write(sact_pkg::REG_ULAST, 32'h0000_FFFF);
		send_random(15);
		reg_write(sact_pkg::REG_USTART, 32'h0202_0200);
		reg_write(sact_pkg::REG_ULAST, 32'h0404_04FF);
		send_random(25);
		reg_write(sact_pkg::REG_USTART, sact_pkg::UNC_START_RST);
		reg_write(sact_pkg::REG_ULAST, sact_pkg::UNC_LAST_RST);
	endtask

	// Hold the result side off so the queue fills and the input stalls
	task automatic test_backpressure();
		hold_req = 80;
		idle_en = 1'b0;
		send_random(12);
		idle_en = 1'b1;
	endtask

	task automatic test_random();
		send_random(50);
		idle_en = 1'b0;
		send_random(40);
		drain();
	endtask

	// Result side stall: long hold-off on request, else random bursts
	always @(posedge clk) begin : stall_gen
		int stall_left;
		if (hold_req > 0) begin
			out_stall <= 1'b1;
			hold_req--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 11);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each result transaction against the oldest expectation
	always @(negedge clk) begin : result_check
		sact_pkg::res_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction");
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (hit !== exp_r.hit) begin
					$error("hit exp %0h got %0h", exp_r.hit, hit); fail_count++;
				end
				if (way !== exp_r.way) begin
					$error("way exp %0h got %0h", exp_r.way, way); fail_count++;
				end
				if (bypass !== exp_r.bypass) begin
					$error("bypass exp %0h got %0h", exp_r.bypass, bypass); fail_count++;
				end
				if (writeback_valid !== exp_r.wb_valid) begin
					$error("writeback_valid exp %0h got %0h", exp_r.wb_valid,
						writeback_valid);
					fail_count++;
				end
				if (writeback_address !== exp_r.wb_addr) begin
					$error("writeback_address exp %0h got %0h", exp_r.wb_addr,
						writeback_address);
					fail_count++;
				end
				if (fill_valid !== exp_r.fill_valid) begin
					$error("fill_valid exp %0h got %0h", exp_r.fill_valid, fill_valid);
					fail_count++;
				end
				if (fill_address !== exp_r.fill_addr) begin
					$error("fill_address exp %0h got %0h", exp_r.fill_addr, fill_address);
					fail_count++;
				end
				if (write_through !== exp_r.wt) begin
					$error("write_through exp %0h got %0h", exp_r.wt, write_through);
					fail_count++;
				end
				if (hit_total !== exp_r.hit_total) begin
					$error("hit_total exp %0h got %0h", exp_r.hit_total, hit_total);
					fail_count++;
				end
				if (miss_total !== exp_r.miss_total) begin
					$error("miss_total exp %0h got %0h", exp_r.miss_total, miss_total);
					fail_count++;
				end
				if (last !== exp_r.last) begin
					$error("last exp %0h got %0h", exp_r.last, last); fail_count++;
				end
			end
		end
	end

	// Main sequence
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		operation = '0;
		address = '0;
		victim_way = 1'b0;
		out_stall = 1'b0;
		sh_enable = 1'b1;
		sh_policy = sact_pkg::POL_WB;
		sh_ustart = sact_pkg::UNC_START_RST;
		sh_ulast = sact_pkg::UNC_LAST_RST;
		sh_hits = 0;
		sh_misses = 0;
		for (int i = 0; i < NLINES; i++) begin
			sh_valid[i] = 1'b0;
			sh_dirty[i] = 1'b0;
			sh_tag[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_policies();
		test_disabled();
		test_region();
		test_backpressure();
		test_random();
		if (fail_count == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#30_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
